// File: rtl/core/swd_pkg.sv
package swd_pkg;

    localparam int DEFAULT_COUNT_BITS = 16;

    localparam int MAG_BITS      = 32;
    localparam int SECONDS_BITS  = 8;
    localparam int LIMIT_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SHAKE_THRESHOLD = 2'd0,
        CFG_WINDOW_SECONDS  = 2'd1,
        CFG_COUNT_LIMIT     = 2'd2,
        CFG_HOLDOFF_SECONDS = 2'd3
    } cfg_idx_t;

    localparam logic [MAG_BITS-1:0]     RST_SHAKE_THRESHOLD = '0;
    localparam logic [SECONDS_BITS-1:0] RST_WINDOW_SECONDS  = 8'd3;
    localparam logic [LIMIT_BITS-1:0]   RST_COUNT_LIMIT     = 16'd10;
    localparam logic [SECONDS_BITS-1:0] RST_HOLDOFF_SECONDS = 8'd3;

    typedef struct packed {
        op_t                     operation;
        logic [MAG_BITS-1:0]     magnitude;
        logic [SECONDS_BITS-1:0] now_seconds;
    } swd_in_t;

    typedef struct packed {
        logic above_threshold;
        logic shake_detected;
    } swd_out_t;

    typedef struct packed {
        logic [MAG_BITS-1:0]     shake_threshold;
        logic [SECONDS_BITS-1:0] window_seconds;
        logic [LIMIT_BITS-1:0]   count_limit;
        logic [SECONDS_BITS-1:0] holdoff_seconds;
    } swd_cfg_t;

endpackage

// File: rtl/core/swd_cfg_regs.sv
module swd_cfg_regs
    import swd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_idx_t                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output swd_cfg_t                 cfg
);

    swd_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.shake_threshold <= RST_SHAKE_THRESHOLD;
            cfg_reg.window_seconds  <= RST_WINDOW_SECONDS;
            cfg_reg.count_limit     <= RST_COUNT_LIMIT;
            cfg_reg.holdoff_seconds <= RST_HOLDOFF_SECONDS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SHAKE_THRESHOLD: begin
                    cfg_reg.shake_threshold <= cfg_data[MAG_BITS-1:0];
                end
                CFG_WINDOW_SECONDS: begin
                    cfg_reg.window_seconds <= cfg_data[SECONDS_BITS-1:0];
                end
                CFG_COUNT_LIMIT: begin
                    cfg_reg.count_limit <= cfg_data[LIMIT_BITS-1:0];
                end
                CFG_HOLDOFF_SECONDS: begin
                    cfg_reg.holdoff_seconds <= cfg_data[SECONDS_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// File: rtl/core/swd_core.sv
module swd_core
    import swd_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  swd_cfg_t cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  swd_in_t  s_word,
    output logic     m_valid,
    input  logic     m_ready,
    output swd_out_t m_word
);

    localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

    logic [COUNT_BITS-1:0]   hit_count_reg,       hit_count_next;
    logic [SECONDS_BITS-1:0] window_elapsed_reg,  window_elapsed_next;
    logic [SECONDS_BITS-1:0] last_shake_time_reg, last_shake_time_next;
    logic                    m_valid_reg;
    swd_out_t                m_word_reg,          m_word_next;

    logic                    accept;
    logic [SECONDS_BITS-1:0] since;
    logic                    sample_hit;
    logic [SECONDS_BITS:0]   tick_age;
    logic                    tick_close;
    logic                    count_met;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    always_comb begin
        since      = s_word.now_seconds - last_shake_time_reg;
        sample_hit = (since >= cfg.holdoff_seconds)
                     && (s_word.magnitude >= cfg.shake_threshold);
        tick_age   = {1'b0, window_elapsed_reg}
                     + {{SECONDS_BITS{1'b0}}, (window_elapsed_reg != '0)};
        tick_close = tick_age > {1'b0, cfg.window_seconds};
        count_met  = CMP_BITS'(hit_count_reg) >= CMP_BITS'(cfg.count_limit);

        hit_count_next       = hit_count_reg;
        window_elapsed_next  = window_elapsed_reg;
        last_shake_time_next = last_shake_time_reg;
        m_word_next          = '0;

        unique case (s_word.operation)
            OP_SAMPLE: begin
                if (sample_hit) begin
                    if (window_elapsed_reg == '0) begin
                        window_elapsed_next = SECONDS_BITS'(1);
                    end
                    if (!(&hit_count_reg)) begin
                        hit_count_next = hit_count_reg + COUNT_BITS'(1);
                    end
                    m_word_next.above_threshold = 1'b1;
                end
            end
            OP_TICK: begin
                if (tick_close) begin
                    if (count_met) begin
                        last_shake_time_next       = s_word.now_seconds;
                        m_word_next.shake_detected = 1'b1;
                    end
                    hit_count_next      = '0;
                    window_elapsed_next = '0;
                end else begin
                    window_elapsed_next = tick_age[SECONDS_BITS-1:0];
                end
            end
            OP_CLEAR: begin
                hit_count_next      = '0;
                window_elapsed_next = '0;
            end
            OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_count_reg       <= '0;
            window_elapsed_reg  <= '0;
            last_shake_time_reg <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (accept) begin
                hit_count_reg       <= hit_count_next;
                window_elapsed_reg  <= window_elapsed_next;
                last_shake_time_reg <= last_shake_time_next;
                m_valid_reg         <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_word_reg <= m_word_next;
        end
    end

    a_window_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (window_elapsed_reg == '0) == (hit_count_reg == '0))
        else $error("window open state disagrees with hit count");

    a_one_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_word_reg.above_threshold && m_word_reg.shake_detected))
        else $error("hit and shake flagged for one word");

    a_shake_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && m_word_next.shake_detected)
        |=> (last_shake_time_reg == $past(s_word.now_seconds)))
        else $error("shake time not recorded");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (!accept && !(s_word.operation == OP_TICK && accept))
        |=> ($stable(hit_count_reg) && $stable(window_elapsed_reg)))
        else $error("state changed without an accepted word");

endmodule

// File: rtl/core/shake_window_detector.sv
// Shake detector: counts accelerometer magnitude words at or above a threshold within a
// window opened by the first hit and aged by one-second tick words; when a tick carries the
// window past its length, a count at or above the limit flags a shake and stamps its time,
// and samples within the holdoff after that shake are ignored. Every input word yields one
// result word. The detector takes one word per clock while no result is held or it is being
// taken: all state and the result register update as the word is accepted, and the result
// register frees as it is taken, so back-to-back words flow with no bubbles. Configuration
// writes are accepted every cycle and should be made only while no word is in flight.
module shake_window_detector
    import swd_pkg::*;
#(
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  swd_in_t                  s_word,
    output logic                     m_valid,
    input  logic                     m_ready,
    output swd_out_t                 m_word,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  cfg_idx_t                 cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    swd_cfg_t cfg;

    swd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

// File: tb/tb_shake_window_detector.sv
module tb_shake_window_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import swd_pkg::*;

    localparam int COUNT_BITS        = DEFAULT_COUNT_BITS;
    localparam int DIRECTED_ROWS     = 34;
    localparam int WIDE_WINDOW_WORDS = 40;
    localparam int RANDOM_PHASES     = 6;
    localparam int PHASE_WORDS       = 220;
    localparam int HOLD_CYCLES       = 400;
    localparam int QUIET_LIMIT       = 4000;

    typedef enum bit {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        cfg_idx_t          index;
        logic [31:0]       data;
        op_t               op;
        logic [31:0]       mag;
        logic [7:0]        now;
        bit                pinned;
        logic              hit;
        logic              shake;
    } script_row_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    swd_in_t                  s_word;
    logic                     m_valid;
    logic                     m_ready;
    swd_out_t                 m_word;
    logic                     cfg_valid;
    logic                     cfg_ready;
    cfg_idx_t                 cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    swd_cfg_t                 shadow_cfg;
    logic [COUNT_BITS-1:0]    hit_total;
    int                       window_age;
    logic [SECONDS_BITS-1:0]  last_shake_at;

    swd_out_t                 expected_q [$];
    script_row_t              script [DIRECTED_ROWS];

    bit idling_on = 1'b1;
    bit hold_req  = 1'b0;
    int words_sent;
    int words_seen;
    int hits_seen;
    int shakes_seen;
    int reg_writes;
    int mismatches;
    int quiet_cycles;

    shake_window_detector #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic swd_out_t predict_detector(swd_in_t w);
        swd_out_t                r;
        logic [SECONDS_BITS-1:0] since;
        int                      next_age;
        r = '0;
        case (w.operation)
            OP_SAMPLE: begin
                since = w.now_seconds - last_shake_at;
                if (since >= shadow_cfg.holdoff_seconds &&
                    w.magnitude >= shadow_cfg.shake_threshold) begin
                    if (window_age == 0) window_age = 1;
                    if (hit_total != '1) hit_total++;
                    r.above_threshold = 1'b1;
                end
            end
            OP_TICK: begin
                next_age = (window_age != 0) ? window_age + 1 : 0;
                if (next_age > int'(shadow_cfg.window_seconds)) begin
                    if (hit_total >= shadow_cfg.count_limit) begin
                        last_shake_at = w.now_seconds;
                        r.shake_detected = 1'b1;
                    end
                    hit_total = '0;
                    window_age = 0;
                end else begin
                    window_age = next_age;
                end
            end
            OP_CLEAR: begin
                hit_total = '0;
                window_age = 0;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("%0t ns: %s mismatch at result word %0d, got %0h want %0h",
                     $time, what, words_seen, got, want);
    endtask

    task automatic send_word(input swd_in_t w, input bit pinned, input swd_out_t pinned_res);
        swd_out_t r;
        while (idling_on && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        do @(posedge aclk); while (!s_ready);
        r = predict_detector(w);
        expected_q.push_back(pinned ? pinned_res : r);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SHAKE_THRESHOLD: shadow_cfg.shake_threshold = data;
            CFG_WINDOW_SECONDS:  shadow_cfg.window_seconds  = data[SECONDS_BITS-1:0];
            CFG_COUNT_LIMIT:     shadow_cfg.count_limit     = data[LIMIT_BITS-1:0];
            CFG_HOLDOFF_SECONDS: shadow_cfg.holdoff_seconds = data[SECONDS_BITS-1:0];
            default: begin
            end
        endcase
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= !(idling_on && $urandom_range(99) < 27);
        end
    end

    always @(posedge aclk) begin : check_results
        swd_out_t want;
        if (aresetn && m_valid && m_ready) begin
            words_seen++;
            hits_seen += int'(m_word.above_threshold);
            shakes_seen += int'(m_word.shake_detected);
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result word", 32'(m_word), 32'd0);
            end else begin
                want = expected_q.pop_front();
                if (m_word.above_threshold !== want.above_threshold)
                    report_mismatch("above_threshold", 32'(m_word.above_threshold),
                                    32'(want.above_threshold));
                if (m_word.shake_detected !== want.shake_detected)
                    report_mismatch("shake_detected", 32'(m_word.shake_detected),
                                    32'(want.shake_detected));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles, %0d results pending",
                     $time, quiet_cycles, expected_q.size());
            $display("tb_shake_window_detector: FAIL");
            $finish;
        end
    end

    initial begin
        swd_in_t                 w;
        swd_out_t                pin;
        logic [31:0]             thr;
        logic [31:0]             d;
        logic [SECONDS_BITS-1:0] win;
        logic [SECONDS_BITS-1:0] hold;
        logic [LIMIT_BITS-1:0]   lim;
        logic [SECONDS_BITS-1:0] clock_now;
        int                      roll;
        int                      pick;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_word    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SHAKE_THRESHOLD;
        cfg_data  = '0;
        quiet_cycles = 0;
        shadow_cfg.shake_threshold = RST_SHAKE_THRESHOLD;
        shadow_cfg.window_seconds  = RST_WINDOW_SECONDS;
        shadow_cfg.count_limit     = RST_COUNT_LIMIT;
        shadow_cfg.holdoff_seconds = RST_HOLDOFF_SECONDS;
        hit_total     = '0;
        window_age    = 0;
        last_shake_at = '0;
        clock_now     = '0;

        script = '{
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 0, 8'd0, 1, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_TICK, 0, 8'd0, 1, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_NONE, 32'hFFFF_FFFF, 8'hFF, 1, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'hFFFF_FFFF, 8'd3, 1, 1, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 0, 8'hFF, 1, 1, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_CLEAR, 0, 8'd3, 1, 0, 0},
            '{ROW_REG, CFG_SHAKE_THRESHOLD, 32'hFFFF_FFFF, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_WINDOW_SECONDS, 32'hFFFF_FF00, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_COUNT_LIMIT, 32'hFFFF_0000, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_HOLDOFF_SECONDS, 32'h0000_0000, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'hFFFF_FFFE, 8'd10, 1, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'hFFFF_FFFF, 8'd10, 1, 1, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_TICK, 0, 8'd11, 1, 0, 1},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_TICK, 0, 8'd12, 1, 0, 0},
            '{ROW_REG, CFG_SHAKE_THRESHOLD, 32'h0000_0100, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_WINDOW_SECONDS, 32'hABCD_12FF, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_COUNT_LIMIT, 32'h5A5A_FFFF, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_HOLDOFF_SECONDS, 32'hFFFF_FFFF, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'h100, 8'd11, 1, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'h100, 8'd10, 1, 1, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_TICK, 0, 8'd10, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_CLEAR, 0, 8'd10, 0, 0, 0},
            '{ROW_REG, CFG_SHAKE_THRESHOLD, 32'd5, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_WINDOW_SECONDS, 32'd1, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_COUNT_LIMIT, 32'd2, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_REG, CFG_HOLDOFF_SECONDS, 32'd2, OP_NONE, 0, 8'd0, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'd5, 8'd20, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'd4, 8'd20, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'd7, 8'd20, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_TICK, 0, 8'd21, 1, 0, 1},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'd9, 8'd22, 1, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_SAMPLE, 32'd9, 8'd23, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_TICK, 0, 8'd23, 0, 0, 0},
            '{ROW_WORD, CFG_SHAKE_THRESHOLD, 0, OP_NONE, 0, 8'd0, 1, 0, 0}
        };

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                settle();
                write_reg(script[i].index, script[i].data);
            end else begin
                w.operation   = script[i].op;
                w.magnitude   = script[i].mag;
                w.now_seconds = script[i].now;
                pin.above_threshold = script[i].hit;
                pin.shake_detected  = script[i].shake;
                send_word(w, script[i].pinned, pin);
            end
        end

        // fill a window with hits, then age the widest window until it closes
        settle();
        write_reg(CFG_SHAKE_THRESHOLD, 32'd0);
        write_reg(CFG_WINDOW_SECONDS, 32'hFF);
        write_reg(CFG_COUNT_LIMIT, 32'hFFFF);
        write_reg(CFG_HOLDOFF_SECONDS, 32'd0);
        idling_on = 1'b0;
        pin = '0;
        w.operation = OP_SAMPLE;
        for (int n = 0; n < WIDE_WINDOW_WORDS; n++) begin
            w.magnitude   = $urandom;
            w.now_seconds = n[SECONDS_BITS-1:0];
            send_word(w, 1'b0, pin);
        end
        w.operation = OP_TICK;
        for (int n = 0; n < 255; n++) send_word(w, 1'b0, pin);
        settle();
        idling_on = 1'b1;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                1: begin
                    thr = '1; win = 8'd1; lim = 16'd1; hold = 8'd0;
                end
                2: begin
                    thr = $urandom; win = 8'd0; lim = 16'd0; hold = 8'hFF;
                end
                3: begin
                    thr = $urandom; win = 8'd254; lim = 16'hFFFF; hold = 8'd1;
                end
                default: begin
                    thr  = $urandom;
                    win  = 8'($urandom_range(1, 6));
                    lim  = 16'($urandom_range(1, 8));
                    hold = 8'($urandom_range(0, 5));
                end
            endcase
            settle();
            write_reg(CFG_SHAKE_THRESHOLD, thr);
            d = $urandom;
            d[SECONDS_BITS-1:0] = win;
            write_reg(CFG_WINDOW_SECONDS, d);
            d = $urandom;
            d[LIMIT_BITS-1:0] = lim;
            write_reg(CFG_COUNT_LIMIT, d);
            d = $urandom;
            d[SECONDS_BITS-1:0] = hold;
            write_reg(CFG_HOLDOFF_SECONDS, d);

            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (ph == RANDOM_PHASES - 1 && n == 100) hold_req = 1'b1;
                roll = $urandom_range(99);
                w.magnitude   = $urandom;
                w.now_seconds = clock_now;
                if (roll < 62) begin
                    w.operation = OP_SAMPLE;
                    pick = $urandom_range(9);
                    if (pick < 4)
                        w.magnitude = (thr > 32'hFFFF_FFFC) ? thr : thr + $urandom_range(3);
                    else if (pick < 6)
                        w.magnitude = thr - $urandom_range(1, 3);
                end else if (roll < 88) begin
                    clock_now++;
                    w.operation   = OP_TICK;
                    w.now_seconds = clock_now;
                end else if (roll < 92) begin
                    w.operation = OP_CLEAR;
                end else if (roll < 95) begin
                    w.operation = OP_NONE;
                end else begin
                    w.operation   = OP_SAMPLE;
                    w.now_seconds = 8'($urandom);
                end
                send_word(w, 1'b0, pin);
            end
        end

        settle();
        repeat (4) @(posedge aclk);

        $display("Sent %0d words across %0d register writes, %0d of them in the wide window run.",
                 words_sent, reg_writes, WIDE_WINDOW_WORDS + 255);
        $display("Results: %0d words checked, %0d counted hits, %0d shakes, %0d mismatches.",
                 words_seen, hits_seen, shakes_seen, mismatches);
        if (mismatches == 0)
            $display("tb_shake_window_detector: PASS");
        else
            $display("tb_shake_window_detector: FAIL");
        $finish;
    end

endmodule
